// ===== hdl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared widths, item types and ratio helpers for the swing pivot detector.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int PRICE_W    = 32;
    localparam int INDEX_W    = 32;
    localparam int THR_W      = 16;
    localparam int THR_FRAC   = 12;
    localparam int PIVOT_W    = 32;
    localparam int PRODUCT_W  = PRICE_W + THR_W;

    localparam logic [PRICE_W-1:0] PRICE_ZERO = '0;
    localparam logic [PRICE_W-1:0] PRICE_ONES = '1;

    typedef enum logic
    {
        MODE_TROUGH = 1'b0,
        MODE_PEAK   = 1'b1
    } spd_mode_t;

    typedef struct packed
    {
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] high_price;
        logic [THR_W-1:0]   ratio_threshold;
    } spd_bar_t;

    typedef struct packed
    {
        logic               emit;
        logic [PIVOT_W-1:0] pivot_index;
        logic               pivot_is_peak;
    } spd_result_t;

    function automatic logic [PRICE_W-1:0] neutral_price(input spd_mode_t mode);
        return (mode == MODE_PEAK) ? PRICE_ONES : PRICE_ZERO;
    endfunction

    // Best opposite price: max in trough mode, min in peak mode.
    function automatic logic [PRICE_W-1:0] best_opp(
        input spd_mode_t          mode,
        input logic [PRICE_W-1:0] a,
        input logic [PRICE_W-1:0] b
    );
        logic [PRICE_W-1:0] r;
        if (mode == MODE_PEAK)
        begin
            r = (a < b) ? a : b;
        end
        else
        begin
            r = (a > b) ? a : b;
        end
        return r;
    endfunction

    // num / den > thr / 2^THR_FRAC, with a zero divisor always exceeding.
    function automatic logic ratio_exceeds(
        input logic [PRICE_W-1:0] num,
        input logic [PRICE_W-1:0] den,
        input logic [THR_W-1:0]   thr
    );
        logic [PRODUCT_W-1:0] lhs;
        logic [PRODUCT_W-1:0] rhs;
        lhs = {{(PRODUCT_W-PRICE_W){1'b0}}, num} << THR_FRAC;
        rhs = PRODUCT_W'(thr) * PRODUCT_W'(den);
        return (den == PRICE_ZERO) || (lhs > rhs);
    endfunction

endpackage

// ===== hdl/spd_if.sv =====
// ----------------------------------------------------------------------------
// spd_if
// Valid/ready channels for price bars in and swing pivots out.
// ----------------------------------------------------------------------------
interface spd_bar_if;
    import spd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] high_price;
    logic [THR_W-1:0]   ratio_threshold;

    modport source (output valid, output low_price, output high_price,
                    output ratio_threshold, input ready);
    modport sink   (input valid, input low_price, input high_price,
                    input ratio_threshold, output ready);
endinterface

interface spd_pivot_if;
    import spd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIVOT_W-1:0] pivot_index;
    logic               pivot_is_peak;

    modport source (output valid, output pivot_index, output pivot_is_peak,
                    input ready);
    modport sink   (input valid, input pivot_index, input pivot_is_peak,
                    output ready);
endinterface

// ===== hdl/spd_core.sv =====
// ----------------------------------------------------------------------------
// spd_core
// Running extreme and opposite-price tracking; one bar per step, single pass.
// ----------------------------------------------------------------------------
module spd_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 step,
    input  spd_pkg::spd_bar_t    bar_item,
    output spd_pkg::spd_result_t result
);
    import spd_pkg::*;

    spd_mode_t          mode_reg;
    logic [INDEX_W-1:0] bar_count_reg, bar_count_next;
    logic               pending_reg, pending_next;
    logic [PRICE_W-1:0] ext_price_reg, ext_price_next;
    logic [INDEX_W-1:0] ext_index_reg, ext_index_next;
    logic [PRICE_W-1:0] ext_opp_reg, ext_opp_next;
    logic [PRICE_W-1:0] opp_to_ext_reg, opp_to_ext_next;
    logic [PRICE_W-1:0] opp_since_reg, opp_since_next;

    spd_mode_t          cfg_mode;
    logic [PRICE_W-1:0] price;
    logic [PRICE_W-1:0] opp;
    logic               better;
    logic               take;
    logic [PRICE_W-1:0] ote1;
    logic [PRICE_W-1:0] ose1;
    logic [PRICE_W-1:0] span;
    logic [PRICE_W-1:0] merged;
    logic               trig;
    logic               ok;

    assign cfg_mode = spd_mode_t'(cfg_wdata);

    always_comb
    begin
        price  = (mode_reg == MODE_PEAK) ? bar_item.high_price : bar_item.low_price;
        opp    = (mode_reg == MODE_PEAK) ? bar_item.low_price  : bar_item.high_price;
        better = (mode_reg == MODE_PEAK) ? (price > ext_price_reg)
                                         : (price < ext_price_reg);
        take   = pending_reg || better;

        ote1           = opp_to_ext_reg;
        ext_price_next = ext_price_reg;
        ext_index_next = ext_index_reg;
        ext_opp_next   = ext_opp_reg;
        ose1           = best_opp(mode_reg, opp_since_reg, opp);
        if (take)
        begin
            if (!pending_reg)
            begin
                ote1 = best_opp(mode_reg, opp_to_ext_reg,
                                best_opp(mode_reg, ext_opp_reg, opp_since_reg));
            end
            ext_price_next = price;
            ext_index_next = bar_count_reg;
            ext_opp_next   = opp;
            ose1           = neutral_price(mode_reg);
        end

        span   = best_opp(mode_reg, ote1, ext_opp_next);
        merged = best_opp(mode_reg, ext_opp_next, ose1);

        if (mode_reg == MODE_PEAK)
        begin
            trig = ratio_exceeds(ext_price_next, bar_item.low_price,
                                 bar_item.ratio_threshold);
            ok   = ratio_exceeds(ext_price_next, span, bar_item.ratio_threshold);
        end
        else
        begin
            trig = ratio_exceeds(bar_item.high_price, ext_price_next,
                                 bar_item.ratio_threshold);
            ok   = ratio_exceeds(span, ext_price_next, bar_item.ratio_threshold);
        end

        bar_count_next = bar_count_reg + INDEX_W'(1);
        if (trig)
        begin
            opp_to_ext_next = ok ? merged : best_opp(mode_reg, ote1, merged);
            opp_since_next  = neutral_price(mode_reg);
            pending_next    = 1'b1;
        end
        else
        begin
            opp_to_ext_next = ote1;
            opp_since_next  = ose1;
            pending_next    = 1'b0;
        end

        result.emit          = trig && ok;
        result.pivot_index   = PIVOT_W'(ext_index_next);
        result.pivot_is_peak = (mode_reg == MODE_PEAK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_TROUGH;
            bar_count_reg  <= '0;
            pending_reg    <= 1'b1;
            ext_price_reg  <= '0;
            ext_index_reg  <= '0;
            ext_opp_reg    <= '0;
            opp_to_ext_reg <= neutral_price(MODE_TROUGH);
            opp_since_reg  <= neutral_price(MODE_TROUGH);
        end
        else if (cfg_we)
        begin
            mode_reg       <= cfg_mode;
            bar_count_reg  <= '0;
            pending_reg    <= 1'b1;
            ext_price_reg  <= '0;
            ext_index_reg  <= '0;
            ext_opp_reg    <= '0;
            opp_to_ext_reg <= neutral_price(cfg_mode);
            opp_since_reg  <= neutral_price(cfg_mode);
        end
        else if (step)
        begin
            bar_count_reg  <= bar_count_next;
            pending_reg    <= pending_next;
            ext_price_reg  <= ext_price_next;
            ext_index_reg  <= ext_index_next;
            ext_opp_reg    <= ext_opp_next;
            opp_to_ext_reg <= opp_to_ext_next;
            opp_since_reg  <= opp_since_next;
        end
    end

endmodule

// ===== hdl/swing_pivot_detector_top.sv =====
// ----------------------------------------------------------------------------
// swing_pivot_detector_top
// Zigzag swing pivot detector over a stream of price bars.
// ----------------------------------------------------------------------------
// Takes one bar per clock cycle at full rate. A bar is captured in an input
// register. When the held bar is consumed, the tracking and ratio-compare
// update runs and a confirmed pivot is loaded into the result register.
// The input register keeps taking bars while a pivot waits in the result
// register; it stalls only when the held bar would confirm a pivot and the
// result register is still full.
// Writing cfg_wdata through cfg_we selects troughs (0) or peaks (1) and
// restarts tracking and the bar index; write only while no bar is in flight.
// ----------------------------------------------------------------------------
module swing_pivot_detector_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    spd_bar_if.sink     bar,
    spd_pivot_if.source pivot
);
    import spd_pkg::*;

    logic               hold_valid_reg;
    spd_bar_t           hold_bar_reg;
    logic               out_valid_reg, out_valid_next;
    logic [PIVOT_W-1:0] out_index_reg;
    logic               out_peak_reg;

    spd_result_t        res;
    logic               out_free;
    logic               consume;
    logic               take_bar;

    spd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (consume),
        .bar_item  (hold_bar_reg),
        .result    (res)
    );

    assign out_free  = !out_valid_reg || pivot.ready;
    assign consume   = hold_valid_reg && (!res.emit || out_free);
    assign bar.ready = !hold_valid_reg || consume;
    assign take_bar  = bar.valid && bar.ready;

    always_comb
    begin
        if (consume && res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pivot.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take_bar)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                hold_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_bar)
        begin
            hold_bar_reg.low_price       <= bar.low_price;
            hold_bar_reg.high_price      <= bar.high_price;
            hold_bar_reg.ratio_threshold <= bar.ratio_threshold;
        end
        if (consume && res.emit)
        begin
            out_index_reg <= res.pivot_index;
            out_peak_reg  <= res.pivot_is_peak;
        end
    end

    assign pivot.valid         = out_valid_reg;
    assign pivot.pivot_index   = out_index_reg;
    assign pivot.pivot_is_peak = out_peak_reg;

endmodule

// ===== hdl/spd_checker.sv =====
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks on the swing pivot detector, bound to the top level.
// ----------------------------------------------------------------------------
module spd_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cfg_we,
    input logic                       cfg_wdata,
    input logic                       bar_valid,
    input logic                       bar_ready,
    input logic                       pivot_valid,
    input logic                       pivot_ready,
    input logic [spd_pkg::PIVOT_W-1:0] pivot_index,
    input logic                       pivot_is_peak
);
    import spd_pkg::*;

    localparam int COUNT_W = PIVOT_W + 1;

    logic               mode_reg;
    logic [COUNT_W-1:0] bars_reg, bars_next;

    always_comb
    begin
        bars_next = bars_reg;
        if (cfg_we)
        begin
            bars_next = '0;
        end
        else if (bar_valid && bar_ready && (bars_reg != {COUNT_W{1'b1}}))
        begin
            bars_next = bars_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            bars_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            bars_reg <= bars_next;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pivot_valid && !pivot_ready |=> pivot_valid && $stable(pivot_index)
            && $stable(pivot_is_peak))
        else $error("pivot changed while stalled");

    a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
        pivot_valid |-> pivot_is_peak == mode_reg)
        else $error("pivot kind differs from selected mode");

    a_index_seen: assert property (@(posedge clk) disable iff (!rst_n)
        pivot_valid |-> COUNT_W'(pivot_index) < bars_reg)
        else $error("pivot index refers to a bar not yet taken");

endmodule

bind swing_pivot_detector_top spd_checker u_spd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .bar_valid     (bar.valid),
    .bar_ready     (bar.ready),
    .pivot_valid   (pivot.valid),
    .pivot_ready   (pivot.ready),
    .pivot_index   (pivot.pivot_index),
    .pivot_is_peak (pivot.pivot_is_peak)
);

// ===== bench/spd_pivot_checker.sv =====
// ----------------------------------------------------------------------------
// spd_pivot_checker
// Watches the bar and pivot channels of the swing pivot detector and checks
// every emitted pivot.
// ----------------------------------------------------------------------------
// Each accepted bar runs through a swing tracker of its own: the running
// extreme, the best opposite price before and after it, and the exact ratio
// compares. Confirmed pivots are queued in order. Each accepted pivot is
// compared field by field against the oldest one. Mode writes restart the
// tracker, as in the block.
// ----------------------------------------------------------------------------
module spd_pivot_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    spd_bar_if          bar,
    spd_pivot_if        pivot,
    output int          fail_count,
    output int          outstanding,
    output int          bars_seen,
    output int          pivots_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import spd_pkg::*;

    typedef struct packed
    {
        logic [PIVOT_W-1:0] index;
        logic               is_peak;
    } pivot_pred_t;

    pivot_pred_t        expected_pivots[$];
    int                 mismatches = 0;
    int                 bar_total = 0;
    int                 pivot_total = 0;
    int                 queued = 0;

    spd_mode_t          track_mode;
    logic [INDEX_W-1:0] next_index;
    bit                 fresh_extreme;
    logic [PRICE_W-1:0] ext_price;
    logic [INDEX_W-1:0] ext_index;
    logic [PRICE_W-1:0] ext_opp;
    logic [PRICE_W-1:0] opp_before;
    logic [PRICE_W-1:0] opp_after;

    assign fail_count  = mismatches;
    assign outstanding = queued;
    assign bars_seen   = bar_total;
    assign pivots_seen = pivot_total;

    function automatic logic [PRICE_W-1:0] blank_opp(input spd_mode_t m);
        return (m == MODE_PEAK) ? {PRICE_W{1'b1}} : {PRICE_W{1'b0}};
    endfunction

    function automatic logic [PRICE_W-1:0] pick_opp(
        input spd_mode_t          m,
        input logic [PRICE_W-1:0] a,
        input logic [PRICE_W-1:0] b
    );
        if (m == MODE_PEAK)
        begin
            return (b < a) ? b : a;
        end
        return (b > a) ? b : a;
    endfunction

    function automatic bit ratio_beats(
        input logic [PRICE_W-1:0] num,
        input logic [PRICE_W-1:0] den,
        input logic [THR_W-1:0]   thr
    );
        logic [63:0] scaled_num;
        logic [63:0] scaled_den;
        if (den == '0)
        begin
            return 1'b1;
        end
        scaled_num = 64'(num) << THR_FRAC;
        scaled_den = 64'(thr) * 64'(den);
        return scaled_num > scaled_den;
    endfunction

    task automatic restart_tracking(input spd_mode_t m);
        track_mode    = m;
        next_index    = '0;
        fresh_extreme = 1'b1;
        ext_price     = '0;
        ext_index     = '0;
        ext_opp       = '0;
        opp_before    = blank_opp(m);
        opp_after     = blank_opp(m);
    endtask

    task automatic track_bar(
        input logic [PRICE_W-1:0] lo,
        input logic [PRICE_W-1:0] hi,
        input logic [THR_W-1:0]   thr
    );
        logic [INDEX_W-1:0] idx;
        logic [PRICE_W-1:0] price;
        logic [PRICE_W-1:0] opp;
        logic [PRICE_W-1:0] span;
        bit                 peak;
        bit                 better;
        bit                 trig;
        bit                 confirmed;
        peak   = (track_mode == MODE_PEAK);
        idx    = next_index;
        price  = peak ? hi : lo;
        opp    = peak ? lo : hi;
        better = peak ? (price > ext_price) : (price < ext_price);
        next_index = next_index + INDEX_W'(1);

        if (fresh_extreme || better)
        begin
            if (!fresh_extreme)
            begin
                opp_before = pick_opp(track_mode, opp_before,
                                      pick_opp(track_mode, ext_opp, opp_after));
            end
            fresh_extreme = 1'b0;
            ext_price     = price;
            ext_index     = idx;
            ext_opp       = opp;
            opp_after     = blank_opp(track_mode);
        end
        else
        begin
            opp_after = pick_opp(track_mode, opp_after, opp);
        end

        trig = peak ? ratio_beats(ext_price, lo, thr) : ratio_beats(hi, ext_price, thr);
        if (trig)
        begin
            span      = pick_opp(track_mode, opp_before, ext_opp);
            confirmed = peak ? ratio_beats(ext_price, span, thr)
                             : ratio_beats(span, ext_price, thr);
            if (confirmed)
            begin
                expected_pivots.push_back('{index: PIVOT_W'(ext_index), is_peak: peak});
                opp_before = pick_opp(track_mode, ext_opp, opp_after);
            end
            else
            begin
                opp_before = pick_opp(track_mode, opp_before,
                                      pick_opp(track_mode, ext_opp, opp_after));
            end
            opp_after     = blank_opp(track_mode);
            fresh_extreme = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] pivot #%0d: %s expected %0h got %0h", $realtime, pivot_total,
                 what, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pivot_pred_t head;
        if (!rst_n)
        begin
            restart_tracking(MODE_TROUGH);
            expected_pivots.delete();
        end
        else
        begin
            if (pivot.valid && pivot.ready)
            begin
                if (expected_pivots.size() == 0)
                begin
                    report_mismatch("unexpected pivot, index", -1,
                                    longint'(pivot.pivot_index));
                end
                else
                begin
                    head = expected_pivots.pop_front();
                    if (pivot.pivot_index !== head.index)
                    begin
                        report_mismatch("pivot_index", longint'(head.index),
                                        longint'(pivot.pivot_index));
                    end
                    if (pivot.pivot_is_peak !== head.is_peak)
                    begin
                        report_mismatch("pivot_is_peak", longint'(head.is_peak),
                                        longint'(pivot.pivot_is_peak));
                    end
                end
                pivot_total++;
            end
            if (cfg_we)
            begin
                restart_tracking(spd_mode_t'(cfg_wdata));
            end
            if (bar.valid && bar.ready)
            begin
                track_bar(bar.low_price, bar.high_price, bar.ratio_threshold);
                bar_total++;
            end
        end
        queued = expected_pivots.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the swing pivot detector.
// ----------------------------------------------------------------------------
// Drives a short directed set of bars in both modes (price extremes, ties,
// zero divisors, zero and full thresholds), then random-walk price series
// with zigzag trends, mixed with noise bars and repeated bars. Both channel
// sides idle at random; one stretch runs back to back and one holds the
// pivot output off long enough to back the block up. Mode writes fall
// between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_STALL  = 250;
    localparam int DRAIN_WAIT  = 8;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    spd_bar_if   bar_ch();
    spd_pivot_if pivot_ch();

    int fail_count;
    int outstanding;
    int bars_seen;
    int pivots_seen;
    int quiet_cycles = 0;

    bit idle_in   = 1'b1;
    bit idle_out  = 1'b1;
    bit stall_req = 1'b0;

    logic [PRICE_W-1:0] walk_price;
    logic [PRICE_W-1:0] last_lo;
    logic [PRICE_W-1:0] last_hi;
    logic [THR_W-1:0]   last_thr;
    bit                 walk_up;
    int                 trend_left = 0;

    swing_pivot_detector_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bar       (bar_ch),
        .pivot     (pivot_ch)
    );

    spd_pivot_checker pivot_watch
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .bar         (bar_ch),
        .pivot       (pivot_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .bars_seen   (bars_seen),
        .pivots_seen (pivots_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (bar_ch.valid && bar_ch.ready) || (pivot_ch.valid && pivot_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("[%0t] no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Pivot receiver: random hold-off per transaction, one long hold on request.
    initial
    begin
        int gap;
        pivot_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = idle_out ? $urandom_range(0, 7) : 0;
            if (stall_req)
            begin
                gap       = LONG_STALL;
                stall_req = 1'b0;
            end
            if (gap > 0)
            begin
                pivot_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pivot_ch.ready <= 1'b1;
            do @(posedge clk); while (!pivot_ch.valid);
            @(negedge clk);
        end
    end

    task automatic push_bar(
        input logic [PRICE_W-1:0] lo,
        input logic [PRICE_W-1:0] hi,
        input logic [THR_W-1:0]   thr
    );
        int gap;
        gap = idle_in ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            bar_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        bar_ch.valid           <= 1'b1;
        bar_ch.low_price       <= lo;
        bar_ch.high_price      <= hi;
        bar_ch.ratio_threshold <= thr;
        last_lo  = lo;
        last_hi  = hi;
        last_thr = thr;
        do @(posedge clk); while (!bar_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain_block();
        bar_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_mode(input spd_mode_t m);
        drain_block();
        cfg_wdata <= m;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_walk_bar();
        longint move;
        longint p;
        longint lo;
        longint hi;
        logic [THR_W-1:0] thr;
        if (trend_left == 0)
        begin
            walk_up    = 1'($urandom_range(0, 1));
            trend_left = $urandom_range(2, 12);
        end
        trend_left--;
        p    = longint'(walk_price);
        move = (longint'($urandom_range(0, 40)) * p) / 1000;
        p    = walk_up ? p + move : p - move;
        if (p > 64'hF000_0000)
        begin
            p       = 64'hF000_0000;
            walk_up = 1'b0;
        end
        if (p < 4096)
        begin
            p       = 4096;
            walk_up = 1'b1;
        end
        walk_price = PRICE_W'(p);
        lo  = p - (p * longint'($urandom_range(0, 15))) / 1000;
        hi  = p + (p * longint'($urandom_range(0, 15))) / 1000;
        if (hi > 64'hFFFF_FFFF)
        begin
            hi = 64'hFFFF_FFFF;
        end
        thr = ($urandom_range(0, 19) == 0) ? THR_W'($urandom_range(0, 65535))
                                           : THR_W'(4096 + $urandom_range(0, 400));
        push_bar(PRICE_W'(lo), PRICE_W'(hi), thr);
    endtask

    task automatic run_random(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                push_bar($urandom, $urandom, THR_W'($urandom_range(0, 65535)));
            end
            else if (pick == 1)
            begin
                push_bar(last_lo, last_hi, last_thr);
            end
            else
            begin
                push_walk_bar();
            end
        end
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= 1'b0;
        bar_ch.valid           <= 1'b0;
        bar_ch.low_price       <= '0;
        bar_ch.high_price      <= '0;
        bar_ch.ratio_threshold <= '0;
        walk_price = PRICE_W'($urandom_range(32'h0001_0000, 32'h4000_0000));
        last_lo    = '0;
        last_hi    = '0;
        last_thr   = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // troughs straight out of reset
        push_bar(32'h0001_0000, 32'h0001_0800, 16'hFFFF);
        push_bar(32'h0001_0000, 32'h0001_0400, 16'hFFFF);
        push_bar(32'h0000_8000, 32'h0000_9000, 16'h1000);
        push_bar(32'h0000_0000, 32'h0000_0000, 16'h1000);
        push_bar(32'h0000_0000, 32'h0000_0001, 16'h0000);
        push_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        push_bar(32'h0010_0000, 32'h0018_0000, 16'h1400);
        push_bar(32'h0008_0000, 32'h0009_0000, 16'h1400);
        push_bar(32'h0008_0000, 32'h0010_0000, 16'h1400);
        push_bar(32'h0002_0000, 32'hFFFF_FFFF, 16'h0000);
        push_bar(32'h0001_0000, 32'h0001_0000, 16'h0FFF);

        write_mode(MODE_PEAK);
        push_bar(32'h0001_0000, 32'h0001_1000, 16'hFFFF);
        push_bar(32'h0001_0800, 32'h0001_1000, 16'hFFFF);
        push_bar(32'h0001_0000, 32'h0002_0000, 16'h1000);
        push_bar(32'h0000_0000, 32'h0001_0000, 16'h1000);
        push_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        push_bar(32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        push_bar(32'h0004_0000, 32'h0008_0000, 16'h1800);
        push_bar(32'h0002_0000, 32'h0003_0000, 16'h1800);
        push_bar(32'h0001_0000, 32'h0002_0000, 16'h1800);
        push_bar(32'h7FFF_FFFF, 32'h8000_0000, 16'h1001);

        write_mode(MODE_TROUGH);
        run_random(500);

        write_mode(MODE_PEAK);
        idle_in  = 1'b0;
        idle_out = 1'b0;
        run_random(400);

        // hold the pivot output while every bar confirms a pivot
        drain_block();
        idle_in   = 1'b1;
        idle_out  = 1'b1;
        stall_req = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            push_bar($urandom, $urandom | 32'h1, 16'h0000);
        end
        run_random(300);

        write_mode(MODE_PEAK);
        idle_out = 1'b0;
        run_random(300);

        write_mode(MODE_TROUGH);
        idle_in  = 1'b0;
        idle_out = 1'b1;
        run_random(500);

        drain_block();
        $display("Covered %0d bars and %0d pivots over trough and peak modes,", bars_seen,
                 pivots_seen);
        $display("with random idling, back-to-back stretches and a long output stall.");
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
